[rtl/assert_macros.svh]
// assertion helpers included by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must hold in the cycle after a trigger
`define ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

[rtl/hpr2_pkg.sv]
// ----------------------------------------------------------------------------
// hpr2_pkg
// Types, constants and arithmetic helpers of the hermitian packed rank-2 update.
// ----------------------------------------------------------------------------
package hpr2_pkg;

	localparam int MAX_N      = 256;
	localparam int IDX_W      = $clog2(MAX_N);
	localparam int CNT_W      = IDX_W + 1;
	localparam int V_W        = 16;
	localparam int A_W        = 40;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic CMD_VECTOR = 1'b0;
	localparam logic CMD_MATRIX = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MATRIX_ORDER = 3'd0,
		REG_TRIANGLE     = 3'd1,
		REG_SIZE         = 3'd2,
		REG_ALPHA_RE     = 3'd3,
		REG_ALPHA_IM     = 3'd4,
		REG_X_REVERSE    = 3'd5,
		REG_Y_REVERSE    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                  matrix_order;
		logic                  triangle;
		logic [CNT_W-1:0]      size;
		logic signed [V_W-1:0] alpha_re;
		logic signed [V_W-1:0] alpha_im;
		logic                  x_reverse;
		logic                  y_reverse;
	} cfg_t;

	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_x_addr;
		logic [IDX_W-1:0] wr_y_addr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_o_addr;
		logic [IDX_W-1:0] rd_i_addr;
		logic             out_load;
		logic             bypass;
		logic             diag;
		logic             last;
	} dp_cmd_t;

	typedef struct packed {
		logic in_ready;
		logic out_valid;
	} ctrl_status_t;

	// Q3.30 sum to Q1.15: add half, floor shift, saturate
	function automatic logic signed [V_W-1:0] rnd15(input logic signed [32:0] v);
		logic signed [33:0] t;
		logic signed [18:0] s;
		t = 34'(v) + 34'sd16384;
		s = 19'(t >>> 15);
		if (s > 19'sd32767)
			return 16'sh7FFF;
		else if (s < -19'sd32768)
			return 16'sh8000;
		else
			return s[V_W-1:0];
	endfunction

	// negate with saturation of the most negative code
	function automatic logic signed [V_W-1:0] neg16(input logic signed [V_W-1:0] v);
		if (v == 16'sh8000)
			return 16'sh7FFF;
		else
			return -v;
	endfunction

	// clamp a 41-bit sum to 40 bits
	function automatic logic signed [A_W-1:0] sat40(input logic signed [A_W:0] v);
		if (v[A_W] != v[A_W-1])
			return v[A_W] ? {1'b1, {(A_W-1){1'b0}}} : {1'b0, {(A_W-1){1'b1}}};
		else
			return v[A_W-1:0];
	endfunction

endpackage

[rtl/hpr2_req_if.sv]
// ----------------------------------------------------------------------------
// hpr2_req_if
// Input item channel: vector pairs and packed matrix elements.
// ----------------------------------------------------------------------------
interface hpr2_req_if import hpr2_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic signed [V_W-1:0] x_re;
	logic signed [V_W-1:0] x_im;
	logic signed [V_W-1:0] y_re;
	logic signed [V_W-1:0] y_im;
	logic signed [A_W-1:0] a_re;
	logic signed [A_W-1:0] a_im;

	modport source (output valid, command, x_re, x_im, y_re, y_im, a_re, a_im, input ready);
	modport sink (input valid, command, x_re, x_im, y_re, y_im, a_re, a_im, output ready);
endinterface

[rtl/hpr2_rsp_if.sv]
// ----------------------------------------------------------------------------
// hpr2_rsp_if
// Result item channel: updated matrix elements.
// ----------------------------------------------------------------------------
interface hpr2_rsp_if import hpr2_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic signed [A_W-1:0] new_re;
	logic signed [A_W-1:0] new_im;
	logic                  last;

	modport source (output valid, new_re, new_im, last, input ready);
	modport sink (input valid, new_re, new_im, last, output ready);
endinterface

[rtl/hpr2_cfg_if.sv]
// ----------------------------------------------------------------------------
// hpr2_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hpr2_cfg_if import hpr2_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/hpr2_ctrl.sv]
// ----------------------------------------------------------------------------
// hpr2_ctrl
// Sequencer: load and traversal counters, packed index walk, datapath commands.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpr2_ctrl import hpr2_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         in_valid,
	input  logic         in_command,
	input  logic         out_ready,
	output ctrl_status_t status,
	output dp_cmd_t      cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

	state_t           state_q;
	logic [1:0]       cnt_q;
	logic [CNT_W-1:0] load_q;
	logic [IDX_W-1:0] outer_q;
	logic [IDX_W-1:0] inner_q;
	logic             last_q;
	logic             bypass_q;
	logic             diag_q;

	logic [CNT_W-1:0] n;
	logic             head_first;
	logic             alpha_zero;
	logic             accept;
	logic             o_wrap;
	logic [IDX_W-1:0] o;
	logic [IDX_W-1:0] in_eff;
	logic [IDX_W-1:0] span_lo;
	logic [IDX_W-1:0] span_hi;
	logic [IDX_W-1:0] i;
	logic [CNT_W-1:0] o_next;
	logic             wrap;
	logic             load_ok;
	logic [IDX_W-1:0] rev_addr;

	// effective size and index walk
	always_comb begin
		n          = (cfg.size > CNT_W'(MAX_N)) ? CNT_W'(MAX_N) : cfg.size;
		head_first = (cfg.matrix_order == cfg.triangle);
		alpha_zero = (cfg.alpha_re == '0) && (cfg.alpha_im == '0);
		accept     = in_valid && (state_q == ST_IDLE);
		o_wrap     = ({1'b0, outer_q} >= n);
		o          = o_wrap ? '0 : outer_q;
		in_eff     = o_wrap ? '0 : inner_q;
		span_lo    = head_first ? '0 : o;
		span_hi    = head_first ? o : IDX_W'(n - CNT_W'(1));
		i          = ((in_eff < span_lo) || (in_eff > span_hi)) ? span_lo : in_eff;
		o_next     = {1'b0, o} + CNT_W'(1);
		wrap       = (o_next >= n);
		load_ok    = (n != '0) && (load_q < n);
		rev_addr   = IDX_W'(n - CNT_W'(1) - load_q);
	end

	// commands and status
	always_comb begin
		cmd.wr_en     = accept && (in_command == CMD_VECTOR) && load_ok;
		cmd.wr_x_addr = cfg.x_reverse ? rev_addr : load_q[IDX_W-1:0];
		cmd.wr_y_addr = cfg.y_reverse ? rev_addr : load_q[IDX_W-1:0];
		cmd.rd_en     = accept && (in_command == CMD_MATRIX);
		cmd.rd_o_addr = o;
		cmd.rd_i_addr = i;
		cmd.out_load  = (state_q == ST_RUN) && (cnt_q == 2'd3);
		cmd.bypass    = bypass_q;
		cmd.diag      = diag_q;
		cmd.last      = last_q;
		status.in_ready  = (state_q == ST_IDLE);
		status.out_valid = (state_q == ST_OUT);
	end

	// state, counters and per-element flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			load_q   <= '0;
			outer_q  <= '0;
			inner_q  <= '0;
			last_q   <= 1'b0;
			bypass_q <= 1'b0;
			diag_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.wr_en) begin
						load_q <= load_q + CNT_W'(1);
					end
					if (cmd.rd_en) begin
						state_q  <= ST_RUN;
						cnt_q    <= '0;
						bypass_q <= (n == '0) || alpha_zero;
						diag_q   <= (i == o);
						if (n == '0) begin
							last_q <= 1'b1;
						end else if (i == span_hi) begin
							outer_q <= wrap ? '0 : o_next[IDX_W-1:0];
							inner_q <= (head_first || wrap) ? '0 : o_next[IDX_W-1:0];
							last_q  <= wrap;
							if (wrap) begin
								load_q <= '0;
							end
						end else begin
							outer_q <= o;
							inner_q <= i + IDX_W'(1);
							last_q  <= 1'b0;
						end
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_one_cmd, clk, arst_n, $onehot0({cmd.wr_en, cmd.rd_en, cmd.out_load}), "overlapping datapath commands")
	`ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, status.out_valid, "result not shown after load")
	`ASSERT_ALWAYS(a_no_overlap, clk, arst_n, !(status.out_valid && status.in_ready), "accepting while a result waits")
	`ASSERT_NEXT(a_start_busy, clk, arst_n, cmd.rd_en, !status.in_ready && !status.out_valid, "element start did not enter run")

endmodule

[rtl/hpr2_dp.sv]
// ----------------------------------------------------------------------------
// hpr2_dp
// Datapath: vector stores, outer term products, rounding, update and saturation.
// ----------------------------------------------------------------------------
module hpr2_dp import hpr2_pkg::*; (
	input  logic                  clk,
	input  cfg_t                  cfg,
	input  dp_cmd_t               cmd,
	input  logic signed [V_W-1:0] x_re,
	input  logic signed [V_W-1:0] x_im,
	input  logic signed [V_W-1:0] y_re,
	input  logic signed [V_W-1:0] y_im,
	input  logic signed [A_W-1:0] a_re,
	input  logic signed [A_W-1:0] a_im,
	output logic signed [A_W-1:0] new_re,
	output logic signed [A_W-1:0] new_im,
	output logic                  last
);

	logic [2*V_W-1:0] x_mem [MAX_N];
	logic [2*V_W-1:0] y_mem [MAX_N];

	logic [2*V_W-1:0]      xo_s1, yo_s1, xi_s1, yi_s1;
	logic signed [A_W-1:0] a_re_s1, a_im_s1;
	logic signed [31:0]    p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2, p6_s2, p7_s2;
	logic signed [V_W-1:0] txr_s3, txi_s3, tyr_s3, tyi_s3;
	logic signed [31:0]    q0_s4, q1_s4, q2_s4, q3_s4, q4_s4, q5_s4, q6_s4, q7_s4;
	logic signed [A_W-1:0] new_re_q, new_im_q;
	logic                  last_q;

	logic signed [V_W-1:0] xo_re, xo_im, yo_re, yo_im;
	logic signed [V_W-1:0] xi_re, xi_im, yi_re, yi_im;
	logic signed [V_W-1:0] txi_r;
	logic signed [32:0]    tyi_sum;
	logic signed [33:0]    tr, ti;

	assign xo_re = xo_s1[V_W-1:0];
	assign xo_im = xo_s1[2*V_W-1:V_W];
	assign yo_re = yo_s1[V_W-1:0];
	assign yo_im = yo_s1[2*V_W-1:V_W];
	assign xi_re = xi_s1[V_W-1:0];
	assign xi_im = xi_s1[2*V_W-1:V_W];
	assign yi_re = yi_s1[V_W-1:0];
	assign yi_im = yi_s1[2*V_W-1:V_W];

	// vector stores, written during load and read at outer and inner index
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			x_mem[cmd.wr_x_addr] <= {x_im, x_re};
			y_mem[cmd.wr_y_addr] <= {y_im, y_re};
		end
		if (cmd.rd_en) begin
			xo_s1   <= x_mem[cmd.rd_o_addr];
			yo_s1   <= y_mem[cmd.rd_o_addr];
			xi_s1   <= x_mem[cmd.rd_i_addr];
			yi_s1   <= y_mem[cmd.rd_i_addr];
			a_re_s1 <= a_re;
			a_im_s1 <= a_im;
		end
	end

	// alpha times outer entries
	always_ff @(posedge clk) begin
		p0_s2 <= cfg.alpha_re * xo_re;
		p1_s2 <= cfg.alpha_im * xo_im;
		p2_s2 <= cfg.alpha_re * xo_im;
		p3_s2 <= cfg.alpha_im * xo_re;
		p4_s2 <= cfg.alpha_re * yo_re;
		p5_s2 <= cfg.alpha_im * yo_im;
		p6_s2 <= cfg.alpha_re * yo_im;
		p7_s2 <= cfg.alpha_im * yo_re;
	end

	// round to Q1.15, conjugate per traversal order
	always_comb begin
		txi_r   = rnd15(33'(p2_s2) + 33'(p3_s2));
		tyi_sum = cfg.matrix_order ? (33'(p6_s2) - 33'(p7_s2)) : (33'(p7_s2) - 33'(p6_s2));
	end

	always_ff @(posedge clk) begin
		txr_s3 <= rnd15(33'(p0_s2) - 33'(p1_s2));
		txi_s3 <= cfg.matrix_order ? txi_r : neg16(txi_r);
		tyr_s3 <= rnd15(33'(p4_s2) + 33'(p5_s2));
		tyi_s3 <= rnd15(tyi_sum);
	end

	// inner entries times outer terms
	always_ff @(posedge clk) begin
		q0_s4 <= xi_re * tyr_s3;
		q1_s4 <= xi_im * tyi_s3;
		q2_s4 <= yi_re * txr_s3;
		q3_s4 <= yi_im * txi_s3;
		q4_s4 <= xi_re * tyi_s3;
		q5_s4 <= xi_im * tyr_s3;
		q6_s4 <= yi_re * txi_s3;
		q7_s4 <= yi_im * txr_s3;
	end

	// term sums at Q.30
	always_comb begin
		if (cfg.matrix_order) begin
			tr = 34'(q0_s4) + 34'(q1_s4) + 34'(q2_s4) + 34'(q3_s4);
			ti = 34'(q4_s4) - 34'(q5_s4) + 34'(q6_s4) - 34'(q7_s4);
		end else begin
			tr = 34'(q0_s4) - 34'(q1_s4) + 34'(q2_s4) - 34'(q3_s4);
			ti = 34'(q4_s4) + 34'(q5_s4) + 34'(q6_s4) + 34'(q7_s4);
		end
	end

	// result register, held until taken
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			last_q <= cmd.last;
			if (cmd.bypass) begin
				new_re_q <= a_re_s1;
				new_im_q <= a_im_s1;
			end else begin
				new_re_q <= sat40(41'(a_re_s1) + 41'(tr));
				new_im_q <= cmd.diag ? '0 : sat40(41'(a_im_s1) + 41'(ti));
			end
		end
	end

	assign new_re = new_re_q;
	assign new_im = new_im_q;
	assign last   = last_q;

endmodule

[rtl/hermitian_packed_rank2_update.sv]
// ----------------------------------------------------------------------------
// hermitian_packed_rank2_update
// Fixed-point packed Hermitian rank-2 update, A + alpha x y^H + conj(alpha) y x^H.
// ----------------------------------------------------------------------------
// Usage:
//   cfg  : write channel for order, triangle, size, alpha, reverse flags, always
//          ready; the user writes them only while idle; not enforced by the block.
//   req  : input items; command 0 loads one x/y pair into the vector stores
//          (pairs beyond the size are dropped), command 1 carries one packed
//          matrix element in the traversal set by order and triangle.
//   rsp  : one result item per matrix element, last marks the final one.
// Operation:
//   a vector pair gives no result. A matrix element is accepted and runs
//   through the store read, outer term multiply, rounding and inner multiply
//   stages into the result register; one element is in flight at a time, so
//   a new element is not accepted before the previous result is taken.
// Reset: counters, state and configuration registers clear; store contents are undefined
//   until loaded. A stalled receiver holds the result and the input stays
//   not ready until the result is taken.
// ----------------------------------------------------------------------------
module hermitian_packed_rank2_update import hpr2_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	hpr2_cfg_if.sink    cfg,
	hpr2_req_if.sink    req,
	hpr2_rsp_if.source  rsp
);

	cfg_t         cfg_q;
	ctrl_status_t status;
	dp_cmd_t      cmd;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_MATRIX_ORDER: cfg_q.matrix_order <= cfg.data[0];
				REG_TRIANGLE:     cfg_q.triangle     <= cfg.data[0];
				REG_SIZE:         cfg_q.size         <= cfg.data[CNT_W-1:0];
				REG_ALPHA_RE:     cfg_q.alpha_re     <= cfg.data[V_W-1:0];
				REG_ALPHA_IM:     cfg_q.alpha_im     <= cfg.data[V_W-1:0];
				REG_X_REVERSE:    cfg_q.x_reverse    <= cfg.data[0];
				REG_Y_REVERSE:    cfg_q.y_reverse    <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	hpr2_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (req.valid),
		.in_command (req.command),
		.out_ready  (rsp.ready),
		.status     (status),
		.cmd        (cmd)
	);

	hpr2_dp u_dp (
		.clk    (clk),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.x_re   (req.x_re),
		.x_im   (req.x_im),
		.y_re   (req.y_re),
		.y_im   (req.y_im),
		.a_re   (req.a_re),
		.a_im   (req.a_im),
		.new_re (rsp.new_re),
		.new_im (rsp.new_im),
		.last   (rsp.last)
	);

	assign req.ready = status.in_ready;
	assign rsp.valid = status.out_valid;

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the packed hermitian rank-2 update: loads vector
// pairs, streams packed triangles under many settings, predicts each updated
// element and compares every result field, with random gaps on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import hpr2_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam int ITEM_GOAL = 1450;
	localparam int FULL_ELEMENTS = 200;

	typedef struct {
		logic signed [A_W-1:0] re;
		logic signed [A_W-1:0] im;
		logic                  last;
	} element_t;

	logic clk;
	logic arst_n;

	hpr2_cfg_if cfg_ch();
	hpr2_req_if req_ch();
	hpr2_rsp_if rsp_ch();

	hermitian_packed_rank2_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// shadow state of the update
	longint vx_re[MAX_N], vx_im[MAX_N], vy_re[MAX_N], vy_im[MAX_N];
	int     loaded, outer_pos, inner_pos;
	logic   m_order, m_tri, rev_x, rev_y;
	int     mat_size;
	longint al_re, al_im;

	element_t updated_q[$];
	int       errors = 0;
	int       item_count = 0;
	bit       quiet = 0;
	bit       hold_request = 0;
	int       idle_cycles = 0;

	// clock
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint clamp40(longint v);
		if (v > 64'sd549755813887) return 64'sd549755813887;
		if (v < -64'sd549755813888) return -64'sd549755813888;
		return v;
	endfunction

	// round a Q3.30 sum to Q1.15
	function automatic longint round_q15(longint v);
		return clamp16((v + 16384) >>> 15);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_MATRIX_ORDER: m_order = d[0];
			REG_TRIANGLE:     m_tri = d[0];
			REG_SIZE:         mat_size = int'(d[8:0]);
			REG_ALPHA_RE:     al_re = longint'($signed(d));
			REG_ALPHA_IM:     al_im = longint'($signed(d));
			REG_X_REVERSE:    rev_x = d[0];
			REG_Y_REVERSE:    rev_y = d[0];
			default: ;
		endcase
	endfunction

	function automatic int active_n();
		return mat_size > MAX_N ? MAX_N : mat_size;
	endfunction

	// vector pair goes to its logical index
	function automatic void store_pair(longint xr, longint xi, longint yr, longint yi);
		int n, px, py;
		n = active_n();
		if (n != 0 && loaded < n) begin
			px = rev_x ? n - 1 - loaded : loaded;
			py = rev_y ? n - 1 - loaded : loaded;
			vx_re[px] = xr;
			vx_im[px] = xi;
			vy_re[py] = yr;
			vy_im[py] = yi;
			loaded++;
		end
	endfunction

	// updated packed element and traversal advance
	function automatic element_t update_element(longint ar, longint ai);
		element_t e;
		int n, o, i, first, stop;
		bit head;
		longint txr, txi, tyr, tyi, tr, ti;
		n = active_n();
		e.last = 1'b0;
		if (n == 0) begin
			e.re = ar;
			e.im = ai;
			e.last = 1'b1;
			return e;
		end
		head = (m_order == m_tri);
		if (outer_pos >= n) begin
			outer_pos = 0;
			inner_pos = 0;
		end
		o = outer_pos;
		first = head ? 0 : o;
		stop = head ? o : n - 1;
		if (inner_pos < first || inner_pos > stop) inner_pos = first;
		i = inner_pos;
		txr = round_q15(al_re * vx_re[o] - al_im * vx_im[o]);
		txi = round_q15(al_re * vx_im[o] + al_im * vx_re[o]);
		if (m_order == 1'b0) begin
			txi = clamp16(-txi);
			tyr = round_q15(al_re * vy_re[o] + al_im * vy_im[o]);
			tyi = round_q15(-al_re * vy_im[o] + al_im * vy_re[o]);
			tr = (vx_re[i] * tyr - vx_im[i] * tyi) + (vy_re[i] * txr - vy_im[i] * txi);
			ti = (vx_re[i] * tyi + vx_im[i] * tyr) + (vy_re[i] * txi + vy_im[i] * txr);
		end else begin
			tyr = round_q15(al_re * vy_re[o] + al_im * vy_im[o]);
			tyi = round_q15(al_re * vy_im[o] - al_im * vy_re[o]);
			tr = (vx_re[i] * tyr + vx_im[i] * tyi) + (vy_re[i] * txr + vy_im[i] * txi);
			ti = (vx_re[i] * tyi - vx_im[i] * tyr) + (vy_re[i] * txi - vy_im[i] * txr);
		end
		if (al_re == 0 && al_im == 0) begin
			e.re = ar;
			e.im = ai;
		end else if (i == o) begin
			e.re = clamp40(ar + tr);
			e.im = '0;
		end else begin
			e.re = clamp40(ar + tr);
			e.im = clamp40(ai + ti);
		end
		if (i == stop) begin
			outer_pos = o + 1;
			if (outer_pos >= n) begin
				outer_pos = 0;
				loaded = 0;
				e.last = 1'b1;
			end
			inner_pos = head ? 0 : outer_pos;
		end else begin
			inner_pos = i + 1;
		end
		return e;
	endfunction

	// offer one item after a random gap and predict it once accepted
	task automatic send_item(logic cmd, logic [15:0] xr, logic [15:0] xi, logic [15:0] yr,
			logic [15:0] yi, logic [39:0] ar, logic [39:0] ai);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.x_re <= xr;
		req_ch.x_im <= xi;
		req_ch.y_re <= yr;
		req_ch.y_im <= yi;
		req_ch.a_re <= ar;
		req_ch.a_im <= ai;
		do @(posedge clk); while (!req_ch.ready);
		item_count++;
		if (cmd == CMD_VECTOR)
			store_pair($signed(xr), $signed(xi), $signed(yr), $signed(yi));
		else
			updated_q.push_back(update_element($signed(ar), $signed(ai)));
	endtask

	// wait until every result is back and the block has drained
	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (updated_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, d);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup(logic ord, logic tri_sel, int n, logic [15:0] are, logic [15:0] aim,
			logic rx, logic ry);
		write_reg(REG_MATRIX_ORDER, 16'(ord));
		write_reg(REG_TRIANGLE, 16'(tri_sel));
		write_reg(REG_SIZE, 16'(n));
		write_reg(REG_ALPHA_RE, are);
		write_reg(REG_ALPHA_IM, aim);
		write_reg(REG_X_REVERSE, 16'(rx));
		write_reg(REG_Y_REVERSE, 16'(ry));
	endtask

	function automatic logic [15:0] pick_q15(bit edges);
		case (edges ? $urandom_range(0, 3) : 4)
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'hFFFF;
			3: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [39:0] pick_q930(bit edges);
		case (edges ? $urandom_range(0, 3) : 4)
			0: return 40'h80_0000_0000;
			1: return 40'h7F_FFFF_FFFF;
			2: return 40'h7F_FF00_0000 + 40'($urandom_range(0, 255));
			3: return 40'h80_0000_0000 + 40'($urandom_range(0, 255));
			default: return {8'($urandom), 32'($urandom)};
		endcase
	endfunction

	task automatic send_pair(bit edges);
		send_item(CMD_VECTOR, pick_q15(edges), pick_q15(edges), pick_q15(edges),
			pick_q15(edges), pick_q930(0), pick_q930(0));
	endtask

	task automatic send_element(bit edges);
		send_item(CMD_MATRIX, pick_q15(0), pick_q15(0), pick_q15(0), pick_q15(0),
			pick_q930(edges), pick_q930(edges));
	endtask

	// full load followed by a whole packed triangle
	task automatic run_matrix(int n, int extra, bit edges);
		repeat (n + extra) send_pair(edges);
		repeat (n * (n + 1) / 2) send_element(edges);
	endtask

	// size zero: pairs dropped, elements pass through marked last
	task automatic test_size_zero();
		setup(0, 0, 0, 16'h4000, 16'h2000, 0, 0);
		send_pair(1);
		send_element(1);
		send_element(1);
		settle();
	endtask

	// extreme operands with saturating sums, both matrix orders
	task automatic test_extremes();
		setup(0, 0, 2, 16'h8000, 16'h8000, 1, 0);
		run_matrix(2, 0, 1);
		settle();
		setup(1, 1, 2, 16'h7FFF, 16'h8000, 0, 1);
		run_matrix(2, 0, 1);
		settle();
	endtask

	// zero alpha passes elements; extra pair and unused register ignored
	task automatic test_alpha_zero();
		setup(1, 0, 1, 16'h0000, 16'h0000, 0, 0);
		write_reg(REG_UNUSED, 16'hFFFF);
		run_matrix(1, 1, 1);
		settle();
	endtask

	// largest size loaded in full, part of its triangle, receiver holds off,
	// then a size change mid-matrix
	task automatic test_full_size();
		setup(0, 1, 511, pick_q15(0), pick_q15(0), 1, 1);
		repeat (MAX_N) send_pair(0);
		repeat (FULL_ELEMENTS) send_element(0);
		hold_request = 1;
		repeat (60) send_element(0);
		settle();
		setup(1, 0, 5, pick_q15(0), pick_q15(0), 0, 1);
		send_pair(0);
		repeat (15) send_element(0);
		settle();
	endtask

	// random settings, mostly small matrices
	task automatic test_random();
		int n;
		while (item_count < ITEM_GOAL) begin
			quiet = ($urandom_range(0, 7) == 0);
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 10);
			setup(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), n,
				($urandom_range(0, 9) == 0) ? 16'h0000 : pick_q15(1),
				($urandom_range(0, 9) == 0) ? 16'h0000 : pick_q15(1),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			run_matrix(n, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0,
				$urandom_range(0, 3) == 0);
			settle();
		end
		quiet = 0;
	endtask

	// result side: random stall per item, with one long hold-off on request
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 0;
				rsp_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			stall = quiet ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// compare each result with the oldest predicted element
	always @(posedge clk) begin
		element_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (updated_q.size() == 0) begin
				$display("%0t: unexpected item re=%0d im=%0d last=%0b", $realtime,
					rsp_ch.new_re, rsp_ch.new_im, rsp_ch.last);
				errors++;
			end else begin
				want = updated_q.pop_front();
				if (rsp_ch.new_re !== want.re) begin
					$display("%0t: new_re expected %0d actual %0d", $realtime, want.re,
						rsp_ch.new_re);
					errors++;
				end
				if (rsp_ch.new_im !== want.im) begin
					$display("%0t: new_im expected %0d actual %0d", $realtime, want.im,
						rsp_ch.new_im);
					errors++;
				end
				if (rsp_ch.last !== want.last) begin
					$display("%0t: last expected %0b actual %0b", $realtime, want.last,
						rsp_ch.last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// test sequence
	initial begin
		loaded = 0;
		outer_pos = 0;
		inner_pos = 0;
		m_order = 0;
		m_tri = 0;
		rev_x = 0;
		rev_y = 0;
		mat_size = 0;
		al_re = 0;
		al_im = 0;
		for (int k = 0; k < MAX_N; k++) begin
			vx_re[k] = 0;
			vx_im[k] = 0;
			vy_re[k] = 0;
			vy_im[k] = 0;
		end
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		req_ch.valid = 1'b0;
		req_ch.command = CMD_VECTOR;
		req_ch.x_re = '0;
		req_ch.x_im = '0;
		req_ch.y_re = '0;
		req_ch.y_im = '0;
		req_ch.a_re = '0;
		req_ch.a_im = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_size_zero();
		test_extremes();
		test_alpha_zero();
		test_full_size();
		test_random();
		settle();
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/hpr2_pkg.sv
rtl/hpr2_req_if.sv
rtl/hpr2_rsp_if.sv
rtl/hpr2_cfg_if.sv
rtl/hpr2_ctrl.sv
rtl/hpr2_dp.sv
rtl/hermitian_packed_rank2_update.sv
tb/sv/testbench.sv
